[rtl/hpc_pkg.sv]
// Shared types, register indexes, reset values and the pulse length clamp
// for the horn pulse controller. No dependencies.
`default_nettype none
package hpc_pkg;

  localparam int unsigned PulseW    = 13;
  localparam int unsigned LockW     = 10;
  localparam int unsigned DebW      = 6;
  localparam int unsigned HoldW     = 7;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CmdW      = 16;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [CfgIndexW-1:0] REG_MIN_PULSE    = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_MAX_PULSE    = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_BUTTON_PULSE = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_LOCKOUT      = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_DEBOUNCE     = 3'd4;

  localparam logic [PulseW-1:0] MIN_PULSE_RST    = 13'd100;
  localparam logic [PulseW-1:0] MAX_PULSE_RST    = 13'd5000;
  localparam logic [PulseW-1:0] BUTTON_PULSE_RST = 13'd1500;
  localparam logic [LockW-1:0]  LOCKOUT_RST      = 10'd500;
  localparam logic [DebW-1:0]   DEBOUNCE_RST     = 6'd30;

  localparam logic [HoldW-1:0]  HOLD_MAX  = '1;
  localparam logic [CountW-1:0] COUNT_MAX = '1;

  localparam logic SRC_REMOTE = 1'b0;
  localparam logic SRC_BUTTON = 1'b1;

  typedef struct packed {
    logic [PulseW-1:0] min_pulse;
    logic [PulseW-1:0] max_pulse;
    logic [PulseW-1:0] button_pulse;
    logic [LockW-1:0]  lockout;
    logic [DebW-1:0]   debounce;
  } hpc_cfg_t;

  typedef struct packed {
    logic              button_down;
    logic              command_valid;
    logic [CmdW-1:0]   command_ms;
  } hpc_item_t;

  typedef struct packed {
    logic              horn_active;
    logic              fired;
    logic              fire_source;
    logic [CountW-1:0] fire_count;
  } hpc_result_t;

  // Lower clamp first, then the upper clamp, so crossed bounds give the maximum.
  function automatic logic [PulseW-1:0] clamp_len(input logic signed [CmdW-1:0] req,
                                                  input logic [PulseW-1:0] lo,
                                                  input logic [PulseW-1:0] hi);
    logic signed [CmdW:0] v;
    logic signed [CmdW:0] lo_s;
    logic signed [CmdW:0] hi_s;
    lo_s = $signed({4'b0, lo});
    hi_s = $signed({4'b0, hi});
    v = (CmdW+1)'(req);
    if (v < lo_s) v = lo_s;
    if (v > hi_s) v = hi_s;
    return v[PulseW-1:0];
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage
`default_nettype wire

[rtl/hpc_if.sv]
// Valid/ready channel interfaces for the tick input and the result output.
// Depends on hpc_pkg for the field widths.
`default_nettype none
interface hpc_in_if;
  import hpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 button_down;
  logic                 command_valid;
  logic signed [CmdW-1:0] command_ms;
  modport source (output valid, button_down, command_valid, command_ms, input ready);
  modport sink   (input valid, button_down, command_valid, command_ms, output ready);
endinterface

interface hpc_out_if;
  import hpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              horn_active;
  logic              fired;
  logic              fire_source;
  logic [CountW-1:0] fire_count;
  modport source (output valid, horn_active, fired, fire_source, fire_count, input ready);
  modport sink   (input valid, horn_active, fired, fire_source, fire_count, output ready);
endinterface
`default_nettype wire

[rtl/hpc_cfg.sv]
// Configuration register file, written through the plain write port.
// Depends on hpc_pkg.
`default_nettype none
module hpc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [hpc_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [hpc_pkg::CfgDataW-1:0]  cfg_data,
  output hpc_pkg::hpc_cfg_t                  cfg
);
  import hpc_pkg::*;

  hpc_cfg_t cfg_r;
  hpc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MIN_PULSE:    cfg_nxt.min_pulse    = cfg_data[PulseW-1:0];
        REG_MAX_PULSE:    cfg_nxt.max_pulse    = cfg_data[PulseW-1:0];
        REG_BUTTON_PULSE: cfg_nxt.button_pulse = cfg_data[PulseW-1:0];
        REG_LOCKOUT:      cfg_nxt.lockout      = cfg_data[LockW-1:0];
        REG_DEBOUNCE:     cfg_nxt.debounce     = cfg_data[DebW-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{MIN_PULSE_RST, MAX_PULSE_RST, BUTTON_PULSE_RST, LOCKOUT_RST, DEBOUNCE_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[rtl/hpc_core.sv]
// Tick state (pulse, lockout, debounce, trigger count) and the single-pass
// update that turns one tick into one result. Depends on hpc_pkg.
`default_nettype none
module hpc_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire hpc_pkg::hpc_item_t  item,
  input  wire hpc_pkg::hpc_cfg_t   cfg,
  output hpc_pkg::hpc_result_t     result
);
  import hpc_pkg::*;

  logic [PulseW-1:0] pulse_left_r, pulse_left_nxt;
  logic [LockW-1:0]  lockout_left_r, lockout_left_nxt;
  logic              ever_fired_r, ever_fired_nxt;
  logic              button_held_r, button_held_nxt;
  logic [HoldW-1:0]  hold_ticks_r, hold_ticks_nxt;
  logic [CountW-1:0] trigger_total_r, trigger_total_nxt;

  logic [PulseW-1:0] pulse_dec;
  logic [LockW-1:0]  lock_dec;
  logic              cmd_fire;
  logic              btn_fire;
  logic [LockW-1:0]  lock_mid;
  logic              ever_mid;
  logic [CountW-1:0] total_mid;

  always_comb begin
    pulse_dec = (pulse_left_r != '0) ? pulse_left_r - 1'b1 : pulse_left_r;
    lock_dec  = (lockout_left_r != '0) ? lockout_left_r - 1'b1 : lockout_left_r;

    cmd_fire  = item.command_valid && (!ever_fired_r || lock_dec == '0);
    lock_mid  = cmd_fire ? cfg.lockout : lock_dec;
    ever_mid  = ever_fired_r | cmd_fire;
    total_mid = cmd_fire ? sat_inc(trigger_total_r) : trigger_total_r;

    button_held_nxt = item.button_down;
    hold_ticks_nxt  = '0;
    btn_fire        = 1'b0;
    if (item.button_down && button_held_r) begin
      hold_ticks_nxt = (hold_ticks_r == HOLD_MAX) ? hold_ticks_r : hold_ticks_r + 1'b1;
      btn_fire = (hold_ticks_nxt > {1'b0, cfg.debounce}) && (!ever_mid || lock_mid == '0);
    end

    if (btn_fire) begin
      pulse_left_nxt = clamp_len(CmdW'({3'b0, cfg.button_pulse}), cfg.min_pulse,
                                 cfg.max_pulse);
    end else if (cmd_fire) begin
      pulse_left_nxt = clamp_len(item.command_ms, cfg.min_pulse, cfg.max_pulse);
    end else begin
      pulse_left_nxt = pulse_dec;
    end
    lockout_left_nxt  = btn_fire ? cfg.lockout : lock_mid;
    ever_fired_nxt    = ever_mid | btn_fire;
    trigger_total_nxt = btn_fire ? sat_inc(total_mid) : total_mid;

    result.horn_active = (pulse_left_nxt != '0);
    result.fired       = cmd_fire | btn_fire;
    result.fire_source = btn_fire ? SRC_BUTTON : SRC_REMOTE;
    result.fire_count  = trigger_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_left_r    <= '0;
      lockout_left_r  <= '0;
      ever_fired_r    <= 1'b0;
      button_held_r   <= 1'b0;
      hold_ticks_r    <= '0;
      trigger_total_r <= '0;
    end else if (step) begin
      pulse_left_r    <= pulse_left_nxt;
      lockout_left_r  <= lockout_left_nxt;
      ever_fired_r    <= ever_fired_nxt;
      button_held_r   <= button_held_nxt;
      hold_ticks_r    <= hold_ticks_nxt;
      trigger_total_r <= trigger_total_nxt;
    end
  end

  a_fire_sets_ever: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.fired |=> ever_fired_r)
    else $error("firing did not mark the controller as having fired");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && !result.fired |=> $stable(trigger_total_r))
    else $error("trigger count moved without a firing");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    trigger_total_r == COUNT_MAX |=> trigger_total_r == COUNT_MAX)
    else $error("trigger count wrapped");

  a_idle_holds_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(pulse_left_r) && $stable(lockout_left_r))
    else $error("timers moved without a tick");

endmodule
`default_nettype wire

[rtl/horn_pulse_controller.sv]
// Horn pulse controller top level: input register, tick update and result register.
// Depends on hpc_pkg, hpc_if, hpc_cfg and hpc_core.
//
// Each input beat on in_beat is one millisecond tick carrying the button level and
// an optional remote command with a signed requested length. Each tick yields
// exactly one result beat on out_beat: horn level after the tick, whether a
// trigger was accepted, its source and the saturating trigger count.
// A beat is taken into the input register on acceptance; at the next edge on
// which the output register is free or being taken, the state is updated and the
// result is loaded into the output register, from which it is offered.
// Throughput is one tick per clock cycle while the receiver keeps out_beat.ready
// high: the state update is a single combinational pass, and the input register
// refills while the output register is being taken.
// When the receiver stalls, the result holds in the output register, one tick
// waits in the input register and in_beat.ready then drops until out_beat moves.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at the next edge;
// indexes beyond the register list are ignored. Synchronous reset (rst_n low)
// empties both registers, restores the register defaults and clears all state.
`default_nettype none
module horn_pulse_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  hpc_in_if.sink                             in_beat,
  hpc_out_if.source                          out_beat,
  input  wire logic                          cfg_we,
  input  wire logic [hpc_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [hpc_pkg::CfgDataW-1:0]  cfg_data
);
  import hpc_pkg::*;

  hpc_cfg_t    cfg;
  hpc_item_t   item_r;
  logic        item_valid_r;
  hpc_result_t result;
  hpc_result_t result_r;
  logic        out_valid_r;
  logic        step;

  hpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hpc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  assign step          = item_valid_r && (!out_valid_r || out_beat.ready);
  assign in_beat.ready = !item_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_beat.ready) begin
        item_valid_r <= in_beat.valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.valid && in_beat.ready) begin
      item_r <= '{in_beat.button_down, in_beat.command_valid, in_beat.command_ms};
    end
    if (step) begin
      result_r <= result;
    end
  end

  assign out_beat.valid       = out_valid_r;
  assign out_beat.horn_active = result_r.horn_active;
  assign out_beat.fired       = result_r.fired;
  assign out_beat.fire_source = result_r.fire_source;
  assign out_beat.fire_count  = result_r.fire_count;

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the horn pulse controller: directed ticks, random tick
// streams under changing settings and back-pressure.
// Depends on hpc_pkg, hpc_if and the horn_pulse_controller RTL.
`default_nettype none
module tb_top;
  import hpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [CfgIndexW-1:0] REG_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  hpc_in_if  tick_ch();
  hpc_out_if result_ch();

  horn_pulse_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (tick_ch),
    .out_beat  (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Local copy of the controller settings and tick state.
  hpc_cfg_t          settings = '{MIN_PULSE_RST, MAX_PULSE_RST, BUTTON_PULSE_RST,
                                  LOCKOUT_RST, DEBOUNCE_RST};
  logic [PulseW-1:0] pulse_left    = '0;
  logic [LockW-1:0]  lockout_left  = '0;
  logic              ever_fired    = 1'b0;
  logic              button_held   = 1'b0;
  logic [HoldW-1:0]  hold_ticks    = '0;
  logic [CountW-1:0] trigger_total = '0;

  hpc_result_t pending_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_req     = 0;
  int unsigned stall_left    = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  function automatic logic [PulseW-1:0] clamped_length(input int req);
    int v;
    v = req;
    if (v < int'(settings.min_pulse)) v = int'(settings.min_pulse);
    if (v > int'(settings.max_pulse)) v = int'(settings.max_pulse);
    return v[PulseW-1:0];
  endfunction

  function automatic void start_pulse(input int req);
    pulse_left   = clamped_length(req);
    lockout_left = settings.lockout;
    ever_fired   = 1'b1;
    if (trigger_total != COUNT_MAX) trigger_total = trigger_total + 1'b1;
  endfunction

  function automatic hpc_result_t predict_horn_tick(input hpc_item_t t);
    hpc_result_t r;
    r = '0;
    if (pulse_left != '0) pulse_left = pulse_left - 1'b1;
    if (lockout_left != '0) lockout_left = lockout_left - 1'b1;
    if (t.command_valid && (!ever_fired || lockout_left == '0)) begin
      start_pulse($signed(t.command_ms));
      r.fired       = 1'b1;
      r.fire_source = SRC_REMOTE;
    end
    if (t.button_down) begin
      if (!button_held) begin
        button_held = 1'b1;
        hold_ticks  = '0;
      end else begin
        if (hold_ticks != HOLD_MAX) hold_ticks = hold_ticks + 1'b1;
        if (hold_ticks > settings.debounce && (!ever_fired || lockout_left == '0)) begin
          start_pulse(int'(settings.button_pulse));
          r.fired       = 1'b1;
          r.fire_source = SRC_BUTTON;
        end
      end
    end else begin
      button_held = 1'b0;
      hold_ticks  = '0;
    end
    r.horn_active = (pulse_left != '0);
    r.fire_count  = trigger_total;
    return r;
  endfunction

  always @(posedge clk) begin
    hpc_item_t t;
    if (rst_n && tick_ch.valid && tick_ch.ready) begin
      t.button_down   = tick_ch.button_down;
      t.command_valid = tick_ch.command_valid;
      t.command_ms    = tick_ch.command_ms;
      pending_results.push_back(predict_horn_tick(t));
    end
  end

  always @(posedge clk) begin
    hpc_result_t exp_r;
    hpc_result_t got;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      got.horn_active = result_ch.horn_active;
      got.fired       = result_ch.fired;
      got.fire_source = result_ch.fire_source;
      got.fire_count  = result_ch.fire_count;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: horn=%0d fired=%0d src=%0d count=%0d",
                   got.horn_active, got.fired, got.fire_source, got.fire_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (got.horn_active !== exp_r.horn_active || got.fired !== exp_r.fired ||
            got.fire_source !== exp_r.fire_source || got.fire_count !== exp_r.fire_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected horn=%0d fired=%0d src=%0d count=%0d,",
                     exp_r.horn_active, exp_r.fired, exp_r.fire_source, exp_r.fire_count,
                     " got horn=%0d fired=%0d src=%0d count=%0d",
                     got.horn_active, got.fired, got.fire_source, got.fire_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_req != 0) begin
      stall_left = stall_req;
      stall_req  = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_tick(input logic btn, input logic cmd, input logic [CmdW-1:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.button_down   <= btn;
    tick_ch.command_valid <= cmd;
    tick_ch.command_ms    <= ms;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input hpc_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_PULSE;
    cfg_data  <= c.min_pulse;
    @(posedge clk);
    cfg_index <= REG_MAX_PULSE;
    cfg_data  <= c.max_pulse;
    @(posedge clk);
    cfg_index <= REG_BUTTON_PULSE;
    cfg_data  <= c.button_pulse;
    @(posedge clk);
    cfg_index <= REG_LOCKOUT;
    cfg_data  <= CfgDataW'(c.lockout);
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= CfgDataW'(c.debounce);
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings  = c;
  endtask

  function automatic logic [PulseW-1:0] random_length();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return PulseW'($urandom);
      default: return PulseW'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic hpc_cfg_t random_settings();
    hpc_cfg_t c;
    c.min_pulse    = random_length();
    c.max_pulse    = random_length();
    c.button_pulse = random_length();
    case ($urandom_range(9))
      0:       c.lockout = '0;
      1:       c.lockout = '1;
      2:       c.lockout = LockW'($urandom);
      default: c.lockout = LockW'($urandom_range(1, 25));
    endcase
    case ($urandom_range(9))
      0:       c.debounce = '0;
      1:       c.debounce = '1;
      2:       c.debounce = DebW'($urandom);
      default: c.debounce = DebW'($urandom_range(1, 6));
    endcase
    return c;
  endfunction

  function automatic logic [CmdW-1:0] random_request();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return CmdW'($urandom);
      default: return CmdW'(int'($urandom_range(70)) - 10);
    endcase
  endfunction

  task automatic test_reset_values();
    send_tick(1'b0, 1'b0, 16'h0000);
    send_tick(1'b0, 1'b1, 16'h7fff);
    send_tick(1'b0, 1'b1, 16'h8000);
    repeat (3) send_tick(1'b1, 1'b0, 16'hffff);
    send_tick(1'b0, 1'b0, 16'h0000);
    wait_for_results();
  endtask

  task automatic test_special_cases();
    // Widest clamp window, zero lockout, zero debounce and zero button length.
    load_config('{13'd0, 13'd8191, 13'd0, 10'd0, 6'd0});
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_tick(1'b0, 1'b1, 16'h8000);
    send_tick(1'b0, 1'b1, 16'h7fff);
    send_tick(1'b1, 1'b0, 16'h0000);
    send_tick(1'b1, 1'b1, 16'h1234);
    send_tick(1'b0, 1'b0, 16'h0000);
    wait_for_results();
    // Crossed clamp bounds and a short lockout that expires exactly.
    load_config('{13'd8191, 13'd0, 13'd8191, 10'd2, 6'd63});
    send_tick(1'b0, 1'b1, 16'd50);
    send_tick(1'b0, 1'b1, 16'd50);
    send_tick(1'b0, 1'b1, 16'hffff);
    send_tick(1'b0, 1'b0, 16'h0000);
    wait_for_results();
    load_config('{13'd3, 13'd6, 13'd5, 10'd1, 6'd1});
    repeat (6) send_tick(1'b1, 1'b0, 16'h0000);
    send_tick(1'b0, 1'b1, 16'd4);
    repeat (3) send_tick(1'b0, 1'b0, 16'h0000);
    wait_for_results();
  endtask

  task automatic test_random_ticks(input int unsigned n, input int unsigned send_pct,
                                   input int unsigned recv_pct);
    logic        btn_level;
    int unsigned run_left;
    logic        btn;
    btn_level     = 1'b0;
    run_left      = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        wait_for_results();
        load_config(random_settings());
      end
      if (run_left == 0) begin
        btn_level = !btn_level;
        if (btn_level)
          run_left = ($urandom_range(9) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 12);
        else
          run_left = $urandom_range(1, 8);
      end
      run_left--;
      btn = ($urandom_range(99) < 5) ? 1'($urandom_range(1)) : btn_level;
      send_tick(btn, ($urandom_range(99) < 15), random_request());
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config('{13'd2, 13'd30, 13'd7, 10'd3, 6'd2});
    stall_req = 120;
    for (int unsigned i = 0; i < 40; i++)
      send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), random_request());
    wait_for_results();
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.button_down   = 1'b0;
    tick_ch.command_valid = 1'b0;
    tick_ch.command_ms    = '0;
    result_ch.ready       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_special_cases();
    test_random_ticks(333, 25, 69);
    test_random_ticks(333, 69, 25);
    test_random_ticks(334, 0, 0);
    test_backpressure();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
